@@ sv/jrs_pkg.sv @@
// jrs_pkg: shared types, codes and constants of the jacobi relaxation sweep unit
package jrs_pkg;

  localparam int JRS_MAX_ROWS = 64;
  localparam int JRS_MAX_COLS = 64;

  localparam int CELL_W = 24;
  localparam int DIM_W  = 7;
  localparam int ACC_W  = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [DIM_W-1:0] ROWS_RST     = 7'd50;
  localparam logic [DIM_W-1:0] COLS_RST     = 7'd50;
  localparam logic [ACC_W-1:0] ACCURACY_RST = 23'd655;

  // item action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_SWEEP = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCURACY = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic [5:0]               row;
    logic [5:0]               col;
    logic signed [CELL_W-1:0] cell_value;
  } jrs_in_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] read_value;
    logic                     changed;
  } jrs_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWA,
    ST_SWB,
    ST_SWC,
    ST_SWD,
    ST_DONE
  } jrs_state_t;

endpackage

@@ sv/jacobi_relaxation_sweep_unit.sv @@
// Jacobi relaxation sweep unit: two grid banks with a stencil sequencer over a shared adder
// Holds a grid of signed Q7.16 cells in two banks and takes one word at a time. A write
// goes from idle to the done state, a read passes through the read state first. A sweep
// runs over every stored cell in raster order with a sequencer around one adder and two
// read ports of the current bank: a cell on the border or outside the grid in use is read
// and copied, an interior cell steps through fetch up and down, fetch left and right, fetch
// centre, average and write. After reset a clearing pass zeroes both banks, one cell a
// cycle, before the first word is taken; configuration writes are taken at any time. A
// result may wait on out_ready while the next word is accepted.
module jacobi_relaxation_sweep_unit
  import jrs_pkg::*;
#(
  parameter int MAX_ROWS = JRS_MAX_ROWS,
  parameter int MAX_COLS = JRS_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  jrs_in_t               in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output jrs_out_t              out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS << CW;
  localparam int SUM_W = CELL_W + 2;

  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLS - 1);

  // banks
  logic [CELL_W-1:0] bank_a_r [DEPTH];
  logic [CELL_W-1:0] bank_b_r [DEPTH];
  logic signed [CELL_W-1:0] a_q0_r, a_q1_r, b_q0_r, b_q1_r;
  logic                     a_we, b_we;
  logic [AW-1:0]            w_addr, ra0, ra1;
  logic [CELL_W-1:0]        w_data;

  // control
  jrs_state_t state_r, state_nxt;
  logic [RW-1:0] i_r, i_nxt, rlim_r, rlim_nxt;
  logic [CW-1:0] j_r, j_nxt, clim_r, clim_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic          moved_r, moved_nxt;
  logic          cur_r, cur_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  jrs_out_t      res_r, res_nxt;
  jrs_out_t      out_word_r, out_word_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [DIM_W-1:0] grid_rows_r, grid_cols_r;
  logic [ACC_W-1:0] accuracy_r;

  // datapath
  logic signed [CELL_W-1:0] src_q0, src_q1, avg_c;
  logic signed [CELL_W:0]   diff_c;
  logic [CELL_W:0]          mag_c;
  logic [RW-1:0]            rlim_c, in_row;
  logic [CW-1:0]            clim_c, in_col;
  logic                     in_inside, interior, last_cell;

  always_ff @(posedge clk) begin
    if (a_we) begin
      bank_a_r[w_addr] <= w_data;
    end
    a_q0_r <= bank_a_r[ra0];
    a_q1_r <= bank_a_r[ra1];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bank_b_r[w_addr] <= w_data;
    end
    b_q0_r <= bank_b_r[ra0];
    b_q1_r <= bank_b_r[ra1];
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROWS_RST;
      grid_cols_r <= COLS_RST;
      accuracy_r  <= ACCURACY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS:     grid_rows_r <= cfg_data[DIM_W-1:0];
        CFG_COLS:     grid_cols_r <= cfg_data[DIM_W-1:0];
        CFG_ACCURACY: accuracy_r  <= cfg_data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  // grid size saturated into range, kept as the index of the last row and column
  always_comb begin
    if (grid_rows_r < DIM_W'(3)) begin
      rlim_c = RW'(2);
    end else if (32'(grid_rows_r) > MAX_ROWS) begin
      rlim_c = LAST_ROW;
    end else begin
      rlim_c = RW'(grid_rows_r - DIM_W'(1));
    end
    if (grid_cols_r < DIM_W'(3)) begin
      clim_c = CW'(2);
    end else if (32'(grid_cols_r) > MAX_COLS) begin
      clim_c = LAST_COL;
    end else begin
      clim_c = CW'(grid_cols_r - DIM_W'(1));
    end
  end

  assign src_q0    = cur_r ? b_q0_r : a_q0_r;
  assign src_q1    = cur_r ? b_q1_r : a_q1_r;
  assign in_inside = (32'(in_word.row) < MAX_ROWS) && (32'(in_word.col) < MAX_COLS);
  assign in_row    = RW'(in_word.row);
  assign in_col    = CW'(in_word.col);
  assign interior  = (i_r != '0) && (i_r < rlim_r) && (j_r != '0) && (j_r < clim_r);
  assign last_cell = (i_r == LAST_ROW) && (j_r == LAST_COL);

  // floor of the exact sum over four, and the distance moved
  assign avg_c  = sum_r[SUM_W-1:2];
  assign diff_c = (CELL_W+1)'(avg_c) - (CELL_W+1)'(src_q0);
  assign mag_c  = diff_c[CELL_W] ? (CELL_W+1)'(-diff_c) : diff_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      i_r         <= '0;
      j_r         <= '0;
      cur_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rlim_r     <= rlim_nxt;
    clim_r     <= clim_nxt;
    sum_r      <= sum_nxt;
    moved_r    <= moved_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rlim_nxt      = rlim_r;
    clim_nxt      = clim_r;
    sum_nxt       = sum_r;
    moved_nxt     = moved_r;
    cur_nxt       = cur_r;
    rd_ok_nxt     = rd_ok_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    a_we          = 1'b0;
    b_we          = 1'b0;
    w_addr        = {i_r, j_r};
    w_data        = '0;
    ra0           = {i_r, j_r};
    ra1           = {i_r, j_r};

    case (state_r)
      ST_CLEAR: begin
        a_we = 1'b1;
        b_we = 1'b1;
        if (last_cell) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        ra0      = {in_row, in_col};
        if (in_valid) begin
          res_nxt   = '0;
          rd_ok_nxt = in_inside;
          state_nxt = ST_DONE;
          case (in_word.action)
            ACT_WRITE: begin
              w_addr = {in_row, in_col};
              w_data = in_word.cell_value;
              a_we   = in_inside && !cur_r;
              b_we   = in_inside && cur_r;
            end
            ACT_SWEEP: begin
              i_nxt     = '0;
              j_nxt     = '0;
              rlim_nxt  = rlim_c;
              clim_nxt  = clim_c;
              moved_nxt = 1'b0;
              state_nxt = ST_SWA;
            end
            ACT_READ: state_nxt = ST_READ;
            default: ;
          endcase
        end
      end

      ST_READ: begin
        res_nxt.read_value = rd_ok_r ? src_q0 : '0;
        state_nxt          = ST_DONE;
      end

      ST_SWA: begin
        if (interior) begin
          ra0 = {i_r - RW'(1), j_r};
          ra1 = {i_r + RW'(1), j_r};
        end
        state_nxt = ST_SWB;
      end

      ST_SWB: begin
        if (interior) begin
          sum_nxt   = SUM_W'(src_q0) + SUM_W'(src_q1);
          ra0       = {i_r, j_r - CW'(1)};
          ra1       = {i_r, j_r + CW'(1)};
          state_nxt = ST_SWC;
        end else begin
          // copy a cell outside the interior unchanged
          w_data = src_q0;
          a_we   = cur_r;
          b_we   = !cur_r;
        end
      end

      ST_SWC: begin
        sum_nxt   = sum_r + SUM_W'(src_q0) + SUM_W'(src_q1);
        state_nxt = ST_SWD;
      end

      ST_SWD: begin
        w_data    = avg_c;
        a_we      = cur_r;
        b_we      = !cur_r;
        moved_nxt = moved_r || (mag_c > (CELL_W+1)'(accuracy_r));
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_word_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // step to the next cell once a cell of the sweep is written
    if (a_we != b_we && state_r != ST_IDLE) begin
      if (last_cell) begin
        res_nxt         = '0;
        res_nxt.changed = moved_nxt;
        cur_nxt         = !cur_r;
        state_nxt       = ST_DONE;
      end else begin
        state_nxt = ST_SWA;
      end
    end

    if (state_r == ST_CLEAR || (a_we != b_we && state_r != ST_IDLE)) begin
      if (j_r == LAST_COL) begin
        j_nxt = '0;
        i_nxt = i_r + RW'(1);
      end else begin
        j_nxt = j_r + CW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ sv/jrs_checker.sv @@
// jrs_checker: port-level assertions for the jacobi relaxation sweep unit, with its bind
module jrs_checker
  import jrs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input jrs_out_t out_word
);

  // one word in flight: no new word straight after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted on two consecutive cycles");

  // a result carries either read data or the sweep flag, never both
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.read_value == '0 || !out_word.changed))
    else $error("result carries read data and a sweep flag");

  // nothing is offered while reset is held
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight out of reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result dropped or changed");

endmodule

bind jacobi_relaxation_sweep_unit jrs_checker u_jrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
